// ----- hw/rtl/frnc_pkg.sv -----
`timescale 1ns / 1ps
package frnc_pkg;

   localparam int MAX_POINTS   = 4096;
   localparam int COORD_BITS   = 16;
   localparam int IDX_BITS     = 12;              // log2(MAX_POINTS)
   localparam int TOTAL_BITS   = IDX_BITS + 1;    // holds MAX_POINTS itself
   localparam int CNT_BITS     = 13;
   localparam int RADIUS_BITS  = 15;
   localparam int BOUND_BITS   = COORD_BITS + 2;  // coord +/- radius, signed
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int SQ_BITS      = 2 * DIFF_BITS;
   localparam int SUM_BITS     = SQ_BITS + 2;
   localparam int R2_BITS      = 2 * RADIUS_BITS;
   localparam int POINT_BITS   = 3 * COORD_BITS;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 15'd2425;

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_QUERY  = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LO_RD,
      ST_LO_CMP,
      ST_HI_RD,
      ST_HI_CMP,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

// ----- hw/rtl/fixed_radius_neighbor_count.sv -----
`timescale 1ns / 1ps
// Fixed-radius neighbor counter. Append beats (tuser 0) store one 3-D point
// each, in arrival order, into a 4096-entry point memory; the user must send
// them in ascending x order, which the block does not enforce. Appends past
// capacity are dropped. A clear beat (tuser 2) empties the store at once. A
// query beat (tuser 1) returns on the rsp channel the number of stored points
// whose squared distance to the query is at most radius squared; tuser 3 is
// dropped. A query runs two binary searches on x through the memory's single
// read port, each step a read followed by a compare, then scans the x window
// at one memory read per cycle, then drains the distance pipeline and hands
// the count to the output register. The next beat is accepted once the query
// has placed its result in the output register, which may still be waiting
// for rsp_tready.
// Program csr_wr_data (radius, unsigned Q15.0 in coordinate units, reset 2425) only while idle.
module fixed_radius_neighbor_count (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [14:0] csr_wr_data,   // radius
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,     // coord_x [15:0], coord_y [31:16], coord_z [47:32]
   input  logic [1:0]  req_tuser,     // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata      // neighbor_count [12:0], zero fill above
);

   // point memory, {z, y, x} per entry
   logic [frnc_pkg::POINT_BITS-1:0] point_mem [frnc_pkg::MAX_POINTS];
   logic [frnc_pkg::POINT_BITS-1:0] rd_data_ff;
   logic                            mem_wr_en;
   logic                            mem_rd_en;
   logic [frnc_pkg::IDX_BITS-1:0]   mem_rd_addr;

   frnc_pkg::state_type state_ff, state_in;

   logic [frnc_pkg::TOTAL_BITS-1:0]  total_ff, total_in;
   logic [frnc_pkg::RADIUS_BITS-1:0] radius_ff;
   logic [frnc_pkg::R2_BITS-1:0]     r2_ff;

   // query operands
   logic signed [frnc_pkg::COORD_BITS-1:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   logic signed [frnc_pkg::BOUND_BITS-1:0] low_ff, low_in, high_ff, high_in;

   // search bounds
   logic [frnc_pkg::IDX_BITS-1:0] l_ff, l_in, h_ff, h_in;
   logic [frnc_pkg::IDX_BITS-1:0] mid_ff, mid_in, lo_ff, lo_in;
   logic [frnc_pkg::IDX_BITS-1:0] scan_ff, scan_in;
   logic [frnc_pkg::IDX_BITS-1:0] mid_lo, mid_hi;
   logic [frnc_pkg::TOTAL_BITS-1:0] lh_sum;

   // scan pipeline
   logic                          rd_vld_ff, rd_vld_in;
   logic                          sq_vld_ff, sq_vld_in;
   logic [frnc_pkg::SQ_BITS-1:0]  sqx_ff, sqy_ff, sqz_ff;
   logic signed [frnc_pkg::DIFF_BITS-1:0] dx, dy, dz;
   logic [frnc_pkg::SUM_BITS-1:0] sq_sum;
   logic [frnc_pkg::CNT_BITS-1:0] count_ff, count_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [frnc_pkg::CNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic                                   req_accept;
   frnc_pkg::kind_type                     req_kind;
   logic signed [frnc_pkg::COORD_BITS-1:0] rd_x, rd_y, rd_z, in_x;
   logic signed [frnc_pkg::BOUND_BITS-1:0] rd_x_ext;

   assign req_tready = (state_ff == frnc_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_kind   = frnc_pkg::kind_type'(req_tuser);
   assign in_x       = req_tdata[frnc_pkg::COORD_BITS-1:0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - frnc_pkg::CNT_BITS){1'b0}}, rsp_count_ff};

   assign rd_x     = rd_data_ff[frnc_pkg::COORD_BITS-1:0];
   assign rd_y     = rd_data_ff[2*frnc_pkg::COORD_BITS-1:frnc_pkg::COORD_BITS];
   assign rd_z     = rd_data_ff[3*frnc_pkg::COORD_BITS-1:2*frnc_pkg::COORD_BITS];
   assign rd_x_ext = frnc_pkg::BOUND_BITS'(rd_x);

   // midpoints: lower search rounds down, upper search rounds up
   assign lh_sum = frnc_pkg::TOTAL_BITS'(l_ff) + frnc_pkg::TOTAL_BITS'(h_ff);
   assign mid_lo = lh_sum[frnc_pkg::TOTAL_BITS-1:1];
   assign mid_hi = frnc_pkg::IDX_BITS'((lh_sum + frnc_pkg::TOTAL_BITS'(1)) >> 1);

   // distance stage 1 operands
   assign dx = frnc_pkg::DIFF_BITS'(qx_ff) - frnc_pkg::DIFF_BITS'(rd_x);
   assign dy = frnc_pkg::DIFF_BITS'(qy_ff) - frnc_pkg::DIFF_BITS'(rd_y);
   assign dz = frnc_pkg::DIFF_BITS'(qz_ff) - frnc_pkg::DIFF_BITS'(rd_z);
   assign sq_sum = frnc_pkg::SUM_BITS'(sqx_ff) + frnc_pkg::SUM_BITS'(sqy_ff)
                 + frnc_pkg::SUM_BITS'(sqz_ff);

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      qz_in        = qz_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      l_in         = l_ff;
      h_in         = h_ff;
      mid_in       = mid_ff;
      lo_in        = lo_ff;
      scan_in      = scan_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = mid_lo;
      rd_vld_in    = 1'b0;
      sq_vld_in    = rd_vld_ff;

      // drop the result beat once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // distance stage 2: compare and count
      if (sq_vld_ff && (sq_sum <= frnc_pkg::SUM_BITS'(r2_ff))) begin
         count_in = count_ff + frnc_pkg::CNT_BITS'(1);
      end

      case (state_ff)
         frnc_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_kind)
                  frnc_pkg::KIND_APPEND: begin
                     if (total_ff < frnc_pkg::TOTAL_BITS'(frnc_pkg::MAX_POINTS)) begin
                        mem_wr_en = 1'b1;
                        total_in  = total_ff + frnc_pkg::TOTAL_BITS'(1);
                     end
                  end
                  frnc_pkg::KIND_QUERY: begin
                     qx_in   = req_tdata[frnc_pkg::COORD_BITS-1:0];
                     qy_in   = req_tdata[2*frnc_pkg::COORD_BITS-1:frnc_pkg::COORD_BITS];
                     qz_in   = req_tdata[3*frnc_pkg::COORD_BITS-1:2*frnc_pkg::COORD_BITS];
                     low_in  = frnc_pkg::BOUND_BITS'(in_x)
                             - frnc_pkg::BOUND_BITS'(radius_ff);
                     high_in = frnc_pkg::BOUND_BITS'(in_x)
                             + frnc_pkg::BOUND_BITS'(radius_ff);
                     count_in = '0;
                     if (total_ff == '0) begin
                        state_in = frnc_pkg::ST_DONE;
                     end else begin
                        l_in     = '0;
                        h_in     = frnc_pkg::IDX_BITS'(total_ff - frnc_pkg::TOTAL_BITS'(1));
                        state_in = frnc_pkg::ST_LO_RD;
                     end
                  end
                  frnc_pkg::KIND_CLEAR: begin
                     total_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         frnc_pkg::ST_LO_RD: begin
            if (l_ff == h_ff) begin
               lo_in    = l_ff;
               l_in     = '0;
               h_in     = frnc_pkg::IDX_BITS'(total_ff - frnc_pkg::TOTAL_BITS'(1));
               state_in = frnc_pkg::ST_HI_RD;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mid_lo;
               mid_in      = mid_lo;
               state_in    = frnc_pkg::ST_LO_CMP;
            end
         end
         frnc_pkg::ST_LO_CMP: begin
            if (rd_x_ext < low_ff) begin
               l_in = mid_ff + frnc_pkg::IDX_BITS'(1);
            end else begin
               h_in = mid_ff;
            end
            state_in = frnc_pkg::ST_LO_RD;
         end
         frnc_pkg::ST_HI_RD: begin
            if (l_ff == h_ff) begin
               // window is [lo_ff, h_ff]; empty when it runs backward
               if (lo_ff > h_ff) begin
                  state_in = frnc_pkg::ST_DONE;
               end else begin
                  scan_in  = lo_ff;
                  state_in = frnc_pkg::ST_SCAN;
               end
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mid_hi;
               mid_in      = mid_hi;
               state_in    = frnc_pkg::ST_HI_CMP;
            end
         end
         frnc_pkg::ST_HI_CMP: begin
            if (rd_x_ext > high_ff) begin
               h_in = mid_ff - frnc_pkg::IDX_BITS'(1);
            end else begin
               l_in = mid_ff;
            end
            state_in = frnc_pkg::ST_HI_RD;
         end
         frnc_pkg::ST_SCAN: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = scan_ff;
            rd_vld_in   = 1'b1;
            if (scan_ff == h_ff) begin
               state_in = frnc_pkg::ST_DRAIN;
            end else begin
               scan_in = scan_ff + frnc_pkg::IDX_BITS'(1);
            end
         end
         frnc_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !sq_vld_ff) begin
               state_in = frnc_pkg::ST_DONE;
            end
         end
         frnc_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = frnc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frnc_pkg::ST_IDLE;
         end
      endcase
   end

   // point memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         point_mem[total_ff[frnc_pkg::IDX_BITS-1:0]] <= req_tdata;
      end
      if (mem_rd_en) begin
         rd_data_ff <= point_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frnc_pkg::ST_IDLE;
         total_ff     <= '0;
         radius_ff    <= frnc_pkg::RADIUS_RESET;
         rd_vld_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rd_vld_ff    <= rd_vld_in;
         sq_vld_ff    <= sq_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      r2_ff        <= frnc_pkg::R2_BITS'(radius_ff) * frnc_pkg::R2_BITS'(radius_ff);
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      qz_ff        <= qz_in;
      low_ff       <= low_in;
      high_ff      <= high_in;
      l_ff         <= l_in;
      h_ff         <= h_in;
      mid_ff       <= mid_in;
      lo_ff        <= lo_in;
      scan_ff      <= scan_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
      // distance stage 1: squares of the differences
      sqx_ff <= frnc_pkg::SQ_BITS'(dx * dx);
      sqy_ff <= frnc_pkg::SQ_BITS'(dy * dy);
      sqz_ff <= frnc_pkg::SQ_BITS'(dz * dz);
   end

   // store fill never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      total_ff <= frnc_pkg::TOTAL_BITS'(frnc_pkg::MAX_POINTS))
      else $error("point total above capacity");

   // an append into a full store leaves the total alone
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_kind == frnc_pkg::KIND_APPEND)
       && (total_ff == frnc_pkg::TOTAL_BITS'(frnc_pkg::MAX_POINTS)))
      |=> $stable(total_ff))
      else $error("append into full store changed total");

   // the scan pipeline is empty whenever a new beat can be taken
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rd_vld_ff && !sq_vld_ff))
      else $error("scan pipeline busy while idle");

   // the scan index never passes the upper window bound
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == frnc_pkg::ST_SCAN) |-> (scan_ff <= h_ff))
      else $error("scan index past window");

   // a result is loaded only from the done state
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(!rsp_valid_ff) && rsp_valid_ff)
      |-> ($past(state_ff) == frnc_pkg::ST_DONE))
      else $error("result loaded outside done state");

endmodule
